>>> hdl/three_wheel_omni_drive_mixer_unit_assert.svh
// assertion macros for the omni drive mixer checker
`ifndef THREE_WHEEL_OMNI_DRIVE_MIXER_UNIT_ASSERT_SVH
`define THREE_WHEEL_OMNI_DRIVE_MIXER_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define TOWDM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("towdm check failed");

// antecedent holds -> consequent holds in the next cycle
`define TOWDM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("towdm check failed");

`endif

>>> hdl/towdm_pkg.sv
// ----------------------------------------------------------------------------
// towdm_pkg
// Shared types, constants and the sine lookup of the omni drive mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package towdm_pkg;

   typedef enum logic [1:0] {
      CSR_LIMIT     = 2'd0,
      CSR_MIN_DRIVE = 2'd1,
      CSR_DEADBAND  = 2'd2
   } csr_index_type;

   localparam logic [6:0] LIMIT_RESET     = 7'd127;
   localparam logic [6:0] MIN_DRIVE_RESET = 7'd20;
   localparam logic [6:0] DEADBAND_RESET  = 7'd3;

   // divider magnitude bits and denominator bits
   localparam int DIV_NUM_W = 15;
   localparam int DIV_DEN_W = 8;
   localparam int DIV_LAT   = DIV_NUM_W + 1;
   // five front stages, three divider layers, four stages between and after
   localparam int PIPE_LATENCY = 9 + 3 * DIV_LAT;

   localparam int WHEEL_ANGLE [3] = '{240, 120, 0};

   localparam int QUARTER_SINE [91] = '{
      0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
      5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
      11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
      16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
      21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
      25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
      28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
      30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
      32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
      32768
   };

   // floor modulo 360 of a value in -496..766
   function automatic logic [8:0] wrap_angle(input logic signed [10:0] s);
      logic signed [10:0] v;
      v = s;
      if (v < 0) v = v + 11'sd360;
      if (v < 0) v = v + 11'sd360;
      if (v >= 11'sd360) v = v - 11'sd360;
      if (v >= 11'sd360) v = v - 11'sd360;
      return v[8:0];
   endfunction

   // sine of a in 0..359 with frac fraction bits, rounded from q1.15
   function automatic int sine_scaled(input logic [8:0] a, input int frac);
      int  t;
      int  dn;
      logic neg;
      neg = 1'b0;
      if (a <= 9'd90) begin
         t = QUARTER_SINE[7'(a)];
      end else if (a <= 9'd180) begin
         t = QUARTER_SINE[7'(9'd180 - a)];
      end else if (a <= 9'd270) begin
         t = QUARTER_SINE[7'(a - 9'd180)];
         neg = 1'b1;
      end else begin
         t = QUARTER_SINE[7'(9'd360 - a)];
         neg = 1'b1;
      end
      if (frac >= 15) begin
         t = t << (frac - 15);
      end else begin
         dn = 15 - frac;
         t = (t + (1 << (dn - 1))) >> dn;
      end
      return neg ? -t : t;
   endfunction

endpackage
`default_nettype wire

>>> hdl/towdm_div.sv
// ----------------------------------------------------------------------------
// towdm_div
// Pipelined restoring divider, one quotient bit per stage, truncates toward
// zero, zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none
module towdm_div #(
   parameter int NUM_W = 15,
   parameter int DEN_W = 8
) (
   input  logic                    clock,
   input  logic signed [NUM_W:0]   num,
   input  logic [DEN_W-1:0]        den,
   output logic signed [NUM_W:0]   quo
);
   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0] numr_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff  [NUM_W];
   logic             neg_ff  [NUM_W];
   logic             zero_ff [NUM_W];
   logic signed [NUM_W:0] quo_out_ff;
   logic [NUM_W-1:0] mag;

   assign mag = num[NUM_W] ? NUM_W'(-num) : NUM_W'(num);

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] num_prev;
      logic [NUM_W-1:0] quo_prev;
      logic [DEN_W-1:0] den_prev;
      logic             neg_prev;
      logic             zero_prev;
      logic [DEN_W:0]   trial;
      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign num_prev  = mag;
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign neg_prev  = num[NUM_W];
         assign zero_prev = (den == '0);
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign num_prev  = numr_ff[i-1];
         assign quo_prev  = quo_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign neg_prev  = neg_ff[i-1];
         assign zero_prev = zero_ff[i-1];
      end
      assign trial = {rem_prev, num_prev[NUM_W-1]};
      always_ff @(posedge clock) begin
         if (trial >= {1'b0, den_prev}) begin
            rem_ff[i] <= DEN_W'(trial - {1'b0, den_prev});
            quo_ff[i] <= {quo_prev[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff[i] <= DEN_W'(trial);
            quo_ff[i] <= {quo_prev[NUM_W-2:0], 1'b0};
         end
         numr_ff[i] <= {num_prev[NUM_W-2:0], 1'b0};
         den_ff[i]  <= den_prev;
         neg_ff[i]  <= neg_prev;
         zero_ff[i] <= zero_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (zero_ff[NUM_W-1]) begin
         quo_out_ff <= '0;
      end else if (neg_ff[NUM_W-1]) begin
         quo_out_ff <= -$signed({1'b0, quo_ff[NUM_W-1]});
      end else begin
         quo_out_ff <= $signed({1'b0, quo_ff[NUM_W-1]});
      end
   end

   assign quo = quo_out_ff;
endmodule
`default_nettype wire

>>> hdl/towdm_dly.sv
// ----------------------------------------------------------------------------
// towdm_dly
// Fixed-length delay line that carries side data and valid past a divider.
// ----------------------------------------------------------------------------
`default_nettype none
module towdm_dly #(
   parameter int W = 8,
   parameter int N = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] sr_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) sr_ff[i] <= '0;
      end else begin
         sr_ff[0] <= din;
         for (int i = 1; i < N; i++) sr_ff[i] <= sr_ff[i-1];
      end
   end

   assign dout = sr_ff[N-1];
endmodule
`default_nettype wire

>>> hdl/three_wheel_omni_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// three_wheel_omni_drive_mixer_unit
// Wheel drives for a 120-degree omni base: sine projection, turn blend,
// shaped heading correction blend.
// ----------------------------------------------------------------------------
// pipeline: an item passes three layers of 16-stage dividers plus nine plain stages
//   between the edge that takes it and the edge that takes its result
// throughput: one item every cycle, busy stays low
// reset: synchronous, clears valid bits and loads register defaults
`default_nettype none
module three_wheel_omni_drive_mixer_unit #(
   parameter int SINE_FRAC_BITS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [8:0]        req_heading_deg,
   input  logic [6:0]        req_drive_power,
   input  logic signed [7:0] req_turn_rate,
   input  logic signed [8:0] req_heading_offset_deg,
   input  logic signed [10:0] req_correction_value,
   output logic              rsp_valid,
   output logic signed [7:0] rsp_wheel_one,
   output logic signed [7:0] rsp_wheel_two,
   output logic signed [7:0] rsp_wheel_three,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data
);
   import towdm_pkg::*;

   localparam int SW = SINE_FRAC_BITS + 2;
   localparam int PW = SW + 8;
   localparam logic signed [PW-1:0] TRUNC_ADJ =
      PW'((64'sd1 <<< SINE_FRAC_BITS) - 64'sd1);

   typedef logic signed [DIV_NUM_W:0] dnum_type;

   // ---------------- configuration ----------------
   logic [6:0] lim_ff, mind_ff, db_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff  <= LIMIT_RESET;
         mind_ff <= MIN_DRIVE_RESET;
         db_ff   <= DEADBAND_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LIMIT:     lim_ff  <= csr_data;
            CSR_MIN_DRIVE: mind_ff <= csr_data;
            CSR_DEADBAND:  db_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage a: angles, correction shaping ----------------
   logic              a_vld_ff;
   logic [8:0]        a_ang_ff [3];
   logic [8:0]        a_ang_in [3];
   logic [6:0]        a_pow_ff;
   logic signed [7:0] a_turn_ff;
   logic signed [7:0] a_corr_ff, a_corr_in;

   always_comb begin
      logic signed [10:0] c;
      logic signed [10:0] l;
      logic [10:0]        m;
      for (int i = 0; i < 3; i++) begin
         a_ang_in[i] = wrap_angle($signed({2'b00, req_heading_deg})
                                  + 11'(req_heading_offset_deg)
                                  - 11'(WHEEL_ANGLE[i]));
      end
      l = $signed({4'b0000, lim_ff});
      c = req_correction_value;
      if (c > l) c = l;
      if (c < -l) c = -l;
      m = c[10] ? 11'(-c) : 11'(c);
      // raise small corrections to the minimum drive, keep the sign
      if (m > {4'b0000, db_ff} && m < {4'b0000, mind_ff}) begin
         c = c[10] ? -$signed({4'b0000, mind_ff}) : $signed({4'b0000, mind_ff});
      end
      if (m <= {4'b0000, db_ff}) c = '0;
      a_corr_in = 8'(c);
   end

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      a_ang_ff  <= a_ang_in;
      a_pow_ff  <= req_drive_power;
      a_turn_ff <= req_turn_rate;
      a_corr_ff <= a_corr_in;
   end

   // ---------------- stage b: sine lookup ----------------
   logic                 b_vld_ff;
   logic signed [SW-1:0] b_sin_ff [3];
   logic [6:0]           b_pow_ff;
   logic signed [7:0]    b_turn_ff;
   logic signed [7:0]    b_corr_ff;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         b_sin_ff[i] <= SW'(sine_scaled(a_ang_ff[i], SINE_FRAC_BITS));
      end
      b_pow_ff  <= a_pow_ff;
      b_turn_ff <= a_turn_ff;
      b_corr_ff <= a_corr_ff;
   end

   // ---------------- stage c: sine times power ----------------
   logic                 c_vld_ff;
   logic signed [PW-1:0] c_prod_ff [3];
   logic [6:0]           c_pow_ff;
   logic signed [7:0]    c_turn_ff;
   logic signed [7:0]    c_corr_ff;

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         c_prod_ff[i] <= PW'(b_sin_ff[i]) * PW'($signed({1'b0, b_pow_ff}));
      end
      c_pow_ff  <= b_pow_ff;
      c_turn_ff <= b_turn_ff;
      c_corr_ff <= b_corr_ff;
   end

   // ---------------- stage d: truncate toward zero ----------------
   logic              d_vld_ff;
   logic signed [7:0] d_w_ff [3];
   logic signed [7:0] d_w_in [3];
   logic [6:0]        d_pow_ff;
   logic signed [7:0] d_turn_ff;
   logic [7:0]        d_z_ff;
   logic [7:0]        d_pz_ff;
   logic signed [7:0] d_corr_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (c_prod_ff[i] < 0) d_w_in[i] = 8'((c_prod_ff[i] + TRUNC_ADJ) >>> SINE_FRAC_BITS);
         else                  d_w_in[i] = 8'(c_prod_ff[i] >>> SINE_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else       d_vld_ff <= c_vld_ff;
   end

   always_ff @(posedge clock) begin
      logic [7:0] z;
      z = c_turn_ff[7] ? 8'(-c_turn_ff) : 8'(c_turn_ff);
      d_w_ff    <= d_w_in;
      d_pow_ff  <= c_pow_ff;
      d_turn_ff <= c_turn_ff;
      d_z_ff    <= z;
      d_pz_ff   <= 8'({1'b0, c_pow_ff} + z);
      d_corr_ff <= c_corr_ff;
   end

   // ---------------- stage e: peak and first numerators ----------------
   logic              e_vld_ff;
   dnum_type          e_n1_ff [3];
   dnum_type          e_nt_ff;
   logic [7:0]        e_m_ff;
   logic [7:0]        e_m_in;
   logic [6:0]        e_pow_ff;
   logic [7:0]        e_pz_ff;
   logic signed [7:0] e_corr_ff;

   always_comb begin
      logic [7:0] a;
      e_m_in = '0;
      for (int i = 0; i < 3; i++) begin
         a = d_w_ff[i][7] ? 8'(-d_w_ff[i]) : 8'(d_w_ff[i]);
         if (a > e_m_in) e_m_in = a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else       e_vld_ff <= d_vld_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e_n1_ff[i] <= dnum_type'(d_w_ff[i]) * dnum_type'($signed({1'b0, d_pow_ff}));
      end
      e_nt_ff   <= dnum_type'(d_turn_ff) * dnum_type'($signed({1'b0, d_z_ff}));
      e_m_ff    <= e_m_in;
      e_pow_ff  <= d_pow_ff;
      e_pz_ff   <= d_pz_ff;
      e_corr_ff <= d_corr_ff;
   end

   // ---------------- divider layer one ----------------
   dnum_type          q1 [3];
   dnum_type          qt;
   logic [23:0]       sb1_in, sb1_out;

   for (genvar i = 0; i < 3; i++) begin : g_div1
      towdm_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
         .clock (clock),
         .num   (e_n1_ff[i]),
         .den   (e_m_ff),
         .quo   (q1[i])
      );
   end

   towdm_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_turn (
      .clock (clock),
      .num   (e_nt_ff),
      .den   (e_pz_ff),
      .quo   (qt)
   );

   assign sb1_in = {e_vld_ff, e_pow_ff, e_pz_ff, e_corr_ff};

   towdm_dly #(.W(24), .N(DIV_LAT)) u_dly1 (
      .clock (clock),
      .reset (reset),
      .din   (sb1_in),
      .dout  (sb1_out)
   );

   // ---------------- stage f: second numerators ----------------
   logic              f_vld_ff;
   dnum_type          f_n2_ff [3];
   logic signed [8:0] f_tt_ff;
   logic [7:0]        f_pz_ff;
   logic signed [7:0] f_corr_ff;

   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else       f_vld_ff <= sb1_out[23];
   end

   always_ff @(posedge clock) begin
      logic signed [7:0] q;
      for (int i = 0; i < 3; i++) begin
         q = 8'(q1[i]);
         f_n2_ff[i] <= dnum_type'(q) * dnum_type'($signed({1'b0, sb1_out[22:16]}));
      end
      f_tt_ff   <= 9'(qt);
      f_pz_ff   <= sb1_out[15:8];
      f_corr_ff <= $signed(sb1_out[7:0]);
   end

   // ---------------- divider layer two ----------------
   dnum_type    q2 [3];
   logic [17:0] sb2_in, sb2_out;

   for (genvar i = 0; i < 3; i++) begin : g_div2
      towdm_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
         .clock (clock),
         .num   (f_n2_ff[i]),
         .den   (f_pz_ff),
         .quo   (q2[i])
      );
   end

   assign sb2_in = {f_vld_ff, f_tt_ff, f_corr_ff};

   towdm_dly #(.W(18), .N(DIV_LAT)) u_dly2 (
      .clock (clock),
      .reset (reset),
      .din   (sb2_in),
      .dout  (sb2_out)
   );

   // ---------------- stage g: turn blend ----------------
   logic              g_vld_ff;
   logic signed [8:0] g_w1_ff [3];
   logic [6:0]        g_z2_ff;
   logic signed [7:0] g_corr_ff;

   always_ff @(posedge clock) begin
      if (reset) g_vld_ff <= 1'b0;
      else       g_vld_ff <= sb2_out[17];
   end

   always_ff @(posedge clock) begin
      logic signed [7:0] c;
      c = $signed(sb2_out[7:0]);
      for (int i = 0; i < 3; i++) begin
         g_w1_ff[i] <= 9'(q2[i]) + $signed(sb2_out[16:8]);
      end
      g_z2_ff   <= c[7] ? 7'(-c) : 7'(c);
      g_corr_ff <= c;
   end

   // ---------------- stage h: second peak and numerators ----------------
   logic       h_vld_ff;
   dnum_type   h_n3_ff [3];
   dnum_type   h_nc_ff;
   logic [7:0] h_den_ff;
   logic [8:0] h_m_in;

   always_comb begin
      logic [8:0] a;
      h_m_in = '0;
      for (int i = 0; i < 3; i++) begin
         a = g_w1_ff[i][8] ? 9'(-g_w1_ff[i]) : 9'(g_w1_ff[i]);
         if (a > h_m_in) h_m_in = a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) h_vld_ff <= 1'b0;
      else       h_vld_ff <= g_vld_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         h_n3_ff[i] <= dnum_type'(g_w1_ff[i]) * dnum_type'($signed({1'b0, h_m_in}));
      end
      h_nc_ff  <= dnum_type'(g_corr_ff) * dnum_type'($signed({1'b0, g_z2_ff}));
      // peak plus correction stays within eight bits
      h_den_ff <= 8'(h_m_in + {2'b00, g_z2_ff});
   end

   // ---------------- divider layer three ----------------
   dnum_type   q3 [3];
   dnum_type   qc;
   logic [0:0] sb3_out;

   for (genvar i = 0; i < 3; i++) begin : g_div3
      towdm_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
         .clock (clock),
         .num   (h_n3_ff[i]),
         .den   (h_den_ff),
         .quo   (q3[i])
      );
   end

   towdm_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_corr (
      .clock (clock),
      .num   (h_nc_ff),
      .den   (h_den_ff),
      .quo   (qc)
   );

   towdm_dly #(.W(1), .N(DIV_LAT)) u_dly3 (
      .clock (clock),
      .reset (reset),
      .din   (h_vld_ff),
      .dout  (sb3_out)
   );

   // ---------------- stage i: result register ----------------
   logic              rsp_valid_ff;
   logic signed [7:0] rsp_w_ff [3];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= sb3_out[0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         rsp_w_ff[i] <= 8'(q3[i] + qc);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_one   = rsp_w_ff[0];
   assign rsp_wheel_two   = rsp_w_ff[1];
   assign rsp_wheel_three = rsp_w_ff[2];
endmodule
`default_nettype wire

>>> hdl/towdm_chk.sv
// ----------------------------------------------------------------------------
// towdm_chk
// Port-level checks of the omni drive mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_wheel_omni_drive_mixer_unit_assert.svh"
module towdm_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [8:0]        req_heading_deg,
   input logic [6:0]        req_drive_power,
   input logic signed [7:0] req_turn_rate,
   input logic signed [8:0] req_heading_offset_deg,
   input logic signed [10:0] req_correction_value,
   input logic              rsp_valid,
   input logic signed [7:0] rsp_wheel_one,
   input logic signed [7:0] rsp_wheel_two,
   input logic signed [7:0] rsp_wheel_three,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [1:0]        csr_index,
   input logic [6:0]        csr_data
);
   import towdm_pkg::*;

   // every result traces back to an item taken a fixed time earlier
   `TOWDM_ASSERT_SAME(a_rsp_has_item, rsp_valid, $past(start && !busy, PIPE_LATENCY))
   // the block never holds an item off
   `TOWDM_ASSERT_SAME(a_no_stall, start, !busy)
   // register writes are always taken
   `TOWDM_ASSERT_SAME(a_cfg_taken, csr_valid, csr_ready)
   `TOWDM_ASSERT_NEXT(a_idle_after_reset, $fell(reset), !rsp_valid)
endmodule
`default_nettype wire

bind three_wheel_omni_drive_mixer_unit towdm_chk u_towdm_chk (.*);

>>> sim/towdm_checker.sv
// ----------------------------------------------------------------------------
// towdm_checker
// Watches the item, result and register channels of the omni drive mixer,
// predicts the three wheel drives of every accepted item and compares them
// in order with the results that come out.
// ----------------------------------------------------------------------------
`default_nettype none
module towdm_checker #(
   parameter int SINE_FRAC_BITS = 15
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [8:0]        req_heading_deg,
   input  wire logic [6:0]        req_drive_power,
   input  wire logic signed [7:0] req_turn_rate,
   input  wire logic signed [8:0] req_heading_offset_deg,
   input  wire logic signed [10:0] req_correction_value,
   input  wire logic              rsp_valid,
   input  wire logic signed [7:0] rsp_wheel_one,
   input  wire logic signed [7:0] rsp_wheel_two,
   input  wire logic signed [7:0] rsp_wheel_three,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [6:0]        csr_data,
   output int                     mismatch_count,
   output int                     drives_pending,
   output int                     drives_checked
);
   import towdm_pkg::*;

   typedef struct packed {
      logic signed [7:0] one;
      logic signed [7:0] two;
      logic signed [7:0] three;
   } wheel_drives_t;

   wheel_drives_t expected_drives[$];
   logic [6:0] limit_q, min_drive_q, deadband_q;

   function automatic int div_or_zero(input int n, input int d);
      return (d == 0) ? 0 : n / d;
   endfunction

   function automatic int abs_int(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int sine_of(input int deg);
      int a, t, up;
      logic neg;
      a = deg % 360;
      if (a < 0) a = a + 360;
      neg = 1'b0;
      if (a <= 90) t = QUARTER_SINE[a];
      else if (a <= 180) t = QUARTER_SINE[180 - a];
      else if (a <= 270) begin
         t = QUARTER_SINE[a - 180];
         neg = 1'b1;
      end else begin
         t = QUARTER_SINE[360 - a];
         neg = 1'b1;
      end
      up = SINE_FRAC_BITS - 15;
      if (up >= 0) t = t << up;
      else t = (t + (1 << (-up - 1))) >>> (-up);
      return neg ? -t : t;
   endfunction

   function automatic wheel_drives_t mix_wheels(input logic [8:0] hd,
         input logic [6:0] pw, input logic signed [7:0] tr,
         input logic signed [8:0] off, input logic signed [10:0] cv);
      int w[3];
      int r[3];
      int power, turn, corr, z, peak, lim, mag;
      longint p;
      wheel_drives_t res;
      power = pw;
      turn = tr;
      corr = cv;
      for (int i = 0; i < 3; i++) begin
         p = longint'(sine_of(int'(hd) + int'(off) - WHEEL_ANGLE[i])) * power;
         w[i] = int'(p / (longint'(1) << SINE_FRAC_BITS));
      end
      z = abs_int(turn);
      peak = 0;
      for (int i = 0; i < 3; i++) if (abs_int(w[i]) > peak) peak = abs_int(w[i]);
      for (int i = 0; i < 3; i++)
         w[i] = div_or_zero(div_or_zero(w[i] * power, peak) * power, power + z)
              + div_or_zero(turn * z, power + z);
      // clamp, then deadband and minimum drive
      lim = limit_q;
      if (corr > lim) corr = lim;
      if (corr < -lim) corr = -lim;
      mag = abs_int(corr);
      if (mag > int'(deadband_q) && mag < int'(min_drive_q))
         corr = (corr < 0) ? -int'(min_drive_q) : int'(min_drive_q);
      if (mag <= int'(deadband_q)) corr = 0;
      z = abs_int(corr);
      peak = 0;
      for (int i = 0; i < 3; i++) if (abs_int(w[i]) > peak) peak = abs_int(w[i]);
      for (int i = 0; i < 3; i++)
         r[i] = div_or_zero(w[i] * peak, peak + z) + div_or_zero(corr * z, peak + z);
      res.one = r[0][7:0];
      res.two = r[1][7:0];
      res.three = r[2][7:0];
      return res;
   endfunction

   task automatic compare_field(input string name, input logic signed [7:0] exp_v,
         input logic signed [7:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      wheel_drives_t exp_d;
      if (reset) begin
         limit_q <= LIMIT_RESET;
         min_drive_q <= MIN_DRIVE_RESET;
         deadband_q <= DEADBAND_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LIMIT:     limit_q <= csr_data;
               CSR_MIN_DRIVE: min_drive_q <= csr_data;
               CSR_DEADBAND:  deadband_q <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            expected_drives.push_back(mix_wheels(req_heading_deg, req_drive_power,
               req_turn_rate, req_heading_offset_deg, req_correction_value));
         if (rsp_valid) begin
            if (expected_drives.size() == 0) begin
               mismatch_count++;
               $display("%0t result with no item waiting: expected none actual %0d %0d %0d",
                  $time, rsp_wheel_one, rsp_wheel_two, rsp_wheel_three);
            end else begin
               exp_d = expected_drives.pop_front();
               compare_field("wheel_one", exp_d.one, rsp_wheel_one);
               compare_field("wheel_two", exp_d.two, rsp_wheel_two);
               compare_field("wheel_three", exp_d.three, rsp_wheel_three);
               drives_checked++;
            end
         end
      end
      drives_pending = expected_drives.size();
   end

   initial begin
      mismatch_count = 0;
      drives_pending = 0;
      drives_checked = 0;
   end
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the omni drive mixer: directed corner items and random bursts
// under several register settings, with the checker beside the block.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import towdm_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [8:0] req_heading_deg = '0;
   logic [6:0] req_drive_power = '0;
   logic signed [7:0] req_turn_rate = '0;
   logic signed [8:0] req_heading_offset_deg = '0;
   logic signed [10:0] req_correction_value = '0;
   logic rsp_valid;
   logic signed [7:0] rsp_wheel_one, rsp_wheel_two, rsp_wheel_three;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_data = '0;
   int mismatch_count, drives_pending, drives_checked;
   int idle_cycles = 0;
   int items_sent = 0;
   int burst_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   three_wheel_omni_drive_mixer_unit uut (.*);

   towdm_checker checker_i (.*);

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // valid drops for one cycle after each write
   task automatic write_reg(input csr_index_type idx, input logic [6:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // start stays high across back-to-back items inside a burst
   task automatic send_item(input logic [8:0] hd, input logic [6:0] pw,
         input logic signed [7:0] tr, input logic signed [8:0] off,
         input logic signed [10:0] cv);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      start <= 1'b1;
      req_heading_deg <= hd;
      req_drive_power <= pw;
      req_turn_rate <= tr;
      req_heading_offset_deg <= off;
      req_correction_value <= cv;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0)
            send_item(9'($urandom), 7'($urandom), $signed(8'($urandom)),
               $signed(9'($urandom)), $signed(11'($urandom)));
         else
            send_item(9'($urandom_range(0, 359)), 7'($urandom_range(0, 127)),
               $signed(8'($urandom_range(0, 254) - 127)),
               $signed(9'($urandom_range(0, 360) - 180)),
               ($urandom_range(0, 1) ? $signed(11'($urandom_range(0, 80) - 40))
                                     : $signed(11'($urandom))));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners at reset register values
      send_item(9'd0, 7'd127, 8'sd0, 9'sd0, 11'sd0);
      send_item(9'd359, 7'd127, 8'sd127, 9'sd0, 11'sd2);
      send_item(9'd511, 7'd127, $signed(8'h80), $signed(9'h100), 11'sd3);
      send_item(9'd90, 7'd0, 8'sd0, 9'sd0, 11'sd0);
      send_item(9'd180, 7'd0, -8'sd127, 9'sd180, 11'sd4);
      send_item(9'd270, 7'd64, 8'sd50, -9'sd180, -11'sd4);
      send_item(9'd45, 7'd127, $signed(8'h80), 9'sd255, 11'sd1023);
      send_item(9'd300, 7'd1, 8'sd1, 9'sd100, $signed(11'h400));
      send_item(9'd120, 7'd100, -8'sd1, -9'sd1, 11'sd19);
      send_item(9'd240, 7'd127, 8'sd0, 9'sd0, -11'sd20);
      send_item(9'd500, 7'd77, 8'sd127, 9'sd255, 11'sd127);
      send_item(9'd0, 7'd0, $signed(8'h80), 9'sd0, 11'sd500);
      drain_results();
      send_random(120);
      // zero limit kills the correction entirely
      drain_results();
      write_reg(CSR_LIMIT, 7'd0);
      send_item(9'd30, 7'd127, 8'sd0, 9'sd0, 11'sd1023);
      send_random(90);
      // minimum drive above the clamp, no deadband
      drain_results();
      write_reg(CSR_LIMIT, 7'd10);
      write_reg(CSR_MIN_DRIVE, 7'd127);
      write_reg(CSR_DEADBAND, 7'd0);
      send_item(9'd10, 7'd50, 8'sd0, 9'sd0, 11'sd1);
      send_item(9'd10, 7'd50, 8'sd0, 9'sd0, $signed(11'h400));
      send_random(90);
      // minimum drive not above deadband
      drain_results();
      write_reg(CSR_LIMIT, 7'd127);
      write_reg(CSR_MIN_DRIVE, 7'd0);
      write_reg(CSR_DEADBAND, 7'd127);
      send_item(9'd200, 7'd90, 8'sd20, 9'sd0, 11'sd127);
      send_random(90);
      drain_results();
      write_reg(CSR_LIMIT, 7'($urandom));
      write_reg(CSR_MIN_DRIVE, 7'($urandom));
      write_reg(CSR_DEADBAND, 7'($urandom_range(0, 20)));
      send_random(100);
      start <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      $display("sent %0d items over five register settings, %0d results checked",
         items_sent, drives_checked);
      if (mismatch_count == 0 && drives_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/towdm_pkg.sv
hdl/towdm_div.sv
hdl/towdm_dly.sv
hdl/three_wheel_omni_drive_mixer_unit.sv
hdl/towdm_chk.sv
sim/towdm_checker.sv
sim/tb_top.sv
